// File: hw/rtl/transform_bounding_box_defines.svh
// -----------------------------------------------------------------------------
// transform_bounding_box_defines: assertion macros
// Shared concurrent-assertion forms for the box transform checks.
// -----------------------------------------------------------------------------
`ifndef TRANSFORM_BOUNDING_BOX_DEFINES_SVH
`define TRANSFORM_BOUNDING_BOX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tbb_pkg.sv
// -----------------------------------------------------------------------------
// tbb_pkg: shared types and constants for the box transform
// Coordinate and accumulator types, register indexes and the saturating
// fixed-point shift used at the output stage.
// -----------------------------------------------------------------------------
`default_nettype none

package tbb_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned COORD_W       = 32;
    localparam int unsigned PROD_W        = 2 * COORD_W;
    localparam int unsigned SUM_W         = PROD_W + 2;
    localparam int unsigned NUM_ROWS      = 3;
    localparam int unsigned NUM_COLS      = 3;
    localparam int unsigned NUM_REGS      = 6;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned BOX_W         = 6 * COORD_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]     t_cfg_data;

    // Register indexes: each row holds cols 0/1 then col 2/translation
    localparam t_cfg_idx REG_ROW0_C01 = 3'd0;
    localparam t_cfg_idx REG_ROW0_C23 = 3'd1;
    localparam t_cfg_idx REG_ROW1_C01 = 3'd2;
    localparam t_cfg_idx REG_ROW1_C23 = 3'd3;
    localparam t_cfg_idx REG_ROW2_C01 = 3'd4;
    localparam t_cfg_idx REG_ROW2_C23 = 3'd5;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Arithmetic shift right by frac (floor), then clamp to the coordinate range
    function automatic t_coord sat_shift(input t_sum v, input int unsigned frac);
        t_sum   sh;
        logic   fits;
        t_coord res;
        sh   = v >>> frac;
        fits = (&sh[SUM_W-1:COORD_W-1]) || !(|sh[SUM_W-1:COORD_W-1]);
        if (fits) begin
            res = sh[COORD_W-1:0];
        end else if (sh[SUM_W-1]) begin
            res = COORD_MIN;
        end else begin
            res = COORD_MAX;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/transform_bounding_box.sv
// -----------------------------------------------------------------------------
// transform_bounding_box: affine transform of an axis-aligned box
// Maps a box through a 3x4 fixed-point matrix and returns the bounds of the
// eight transformed corners, computed per row as the sum of per-column
// minimum (maximum) products plus translation, shifted and saturated.
//
//   Channel   Direction  Payload
//   s_axis    in         box min x/y/z, max x/y/z (6 x 32 bit)
//   m_axis    out        transformed min x/y/z, max x/y/z (6 x 32 bit)
//   cfg       in         index 3 bit, data 64 bit (matrix rows)
//
// One box per cycle while the output is not stalled, through five register
// stages: multiply, column min/max, partial sums, final sum, shift/saturate.
// Output valid is the valid bit of the last stage, beside its registered result.
// Reset (synchronous, active low) empties the pipeline and loads the identity.
// A stalled output holds every stage that is full behind it; empty stages keep
// filling, so no transaction is dropped or repeated.
// -----------------------------------------------------------------------------
`default_nettype none

module transform_bounding_box
    import tbb_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tdata: min_x [31:0], min_y [63:32], min_z [95:64],
    //        max_x [127:96], max_y [159:128], max_z [191:160]
    input  wire logic                  i_s_axis_tvalid,
    output      logic                  o_s_axis_tready,
    input  wire logic [BOX_W-1:0]      i_s_axis_tdata,
    // tdata: min_x [31:0], min_y [63:32], min_z [95:64],
    //        max_x [127:96], max_y [159:128], max_z [191:160]
    output      logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output      logic [BOX_W-1:0]      o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire t_cfg_idx              i_cfg_index,
    input  wire t_cfg_data             i_cfg_data
);

    localparam int unsigned NUM_STAGES = 5;
    localparam t_cfg_data   ONE_FIX    = t_cfg_data'(1) << FRAC_BITS;

    // Configuration registers
    t_cfg_data r_cfg [NUM_REGS];

    // Stage valids and ready chain
    logic [NUM_STAGES:1] r_v;
    logic [NUM_STAGES:1] w_rdy;

    // Unpacked views
    t_coord w_lo [NUM_COLS];
    t_coord w_hi [NUM_COLS];
    t_coord w_m  [NUM_ROWS][NUM_COLS+1];

    // Pipeline payload
    t_prod  r_s1_plo [NUM_ROWS][NUM_COLS];
    t_prod  r_s1_phi [NUM_ROWS][NUM_COLS];
    t_coord r_s1_tr  [NUM_ROWS];
    t_prod  r_s2_mn  [NUM_ROWS][NUM_COLS];
    t_prod  r_s2_mx  [NUM_ROWS][NUM_COLS];
    t_sum   r_s2_tr  [NUM_ROWS];
    t_sum   r_s3_mn_a [NUM_ROWS];
    t_sum   r_s3_mn_b [NUM_ROWS];
    t_sum   r_s3_mx_a [NUM_ROWS];
    t_sum   r_s3_mx_b [NUM_ROWS];
    t_sum   r_s4_mn  [NUM_ROWS];
    t_sum   r_s4_mx  [NUM_ROWS];
    t_coord r_out_mn [NUM_ROWS];
    t_coord r_out_mx [NUM_ROWS];

    // Write configuration; indexes past the list are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ROW0_C01] <= ONE_FIX;
            r_cfg[REG_ROW0_C23] <= '0;
            r_cfg[REG_ROW1_C01] <= ONE_FIX << COORD_W;
            r_cfg[REG_ROW1_C23] <= '0;
            r_cfg[REG_ROW2_C01] <= '0;
            r_cfg[REG_ROW2_C23] <= ONE_FIX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ROW0_C01: r_cfg[REG_ROW0_C01] <= i_cfg_data;
                REG_ROW0_C23: r_cfg[REG_ROW0_C23] <= i_cfg_data;
                REG_ROW1_C01: r_cfg[REG_ROW1_C01] <= i_cfg_data;
                REG_ROW1_C23: r_cfg[REG_ROW1_C23] <= i_cfg_data;
                REG_ROW2_C01: r_cfg[REG_ROW2_C01] <= i_cfg_data;
                REG_ROW2_C23: r_cfg[REG_ROW2_C23] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Split input corners and matrix entries
    always_comb begin
        for (int k = 0; k < NUM_COLS; k++) begin
            w_lo[k] = i_s_axis_tdata[k*COORD_W +: COORD_W];
            w_hi[k] = i_s_axis_tdata[(k+NUM_COLS)*COORD_W +: COORD_W];
        end
        for (int r = 0; r < NUM_ROWS; r++) begin
            w_m[r][0] = r_cfg[2*r][COORD_W-1:0];
            w_m[r][1] = r_cfg[2*r][CFG_DATA_W-1:COORD_W];
            w_m[r][2] = r_cfg[2*r+1][COORD_W-1:0];
            w_m[r][3] = r_cfg[2*r+1][CFG_DATA_W-1:COORD_W];
        end
    end

    // Ready chain: a stage advances when empty or when the next one advances
    always_comb begin
        w_rdy[NUM_STAGES] = !r_v[NUM_STAGES] || i_m_axis_tready;
        for (int s = NUM_STAGES - 1; s >= 1; s--) begin
            w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    end

    assign o_s_axis_tready = w_rdy[1];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_v[1] <= i_s_axis_tvalid;
            end
            for (int s = 2; s <= NUM_STAGES; s++) begin
                if (w_rdy[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // Stage 1: products of each entry with both corner coordinates
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int j = 0; j < NUM_COLS; j++) begin
                    r_s1_plo[r][j] <= t_prod'(w_m[r][j]) * t_prod'(w_lo[j]);
                    r_s1_phi[r][j] <= t_prod'(w_m[r][j]) * t_prod'(w_hi[j]);
                end
                r_s1_tr[r] <= w_m[r][NUM_COLS];
            end
        end
    end

    // Stage 2: pick per-column min and max, scale translation by one
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int j = 0; j < NUM_COLS; j++) begin
                    if (r_s1_plo[r][j] < r_s1_phi[r][j]) begin
                        r_s2_mn[r][j] <= r_s1_plo[r][j];
                        r_s2_mx[r][j] <= r_s1_phi[r][j];
                    end else begin
                        r_s2_mn[r][j] <= r_s1_phi[r][j];
                        r_s2_mx[r][j] <= r_s1_plo[r][j];
                    end
                end
                r_s2_tr[r] <= t_sum'(r_s1_tr[r]) <<< FRAC_BITS;
            end
        end
    end

    // Stage 3: partial sums
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_s3_mn_a[r] <= t_sum'(r_s2_mn[r][0]) + t_sum'(r_s2_mn[r][1]);
                r_s3_mn_b[r] <= t_sum'(r_s2_mn[r][2]) + r_s2_tr[r];
                r_s3_mx_a[r] <= t_sum'(r_s2_mx[r][0]) + t_sum'(r_s2_mx[r][1]);
                r_s3_mx_b[r] <= t_sum'(r_s2_mx[r][2]) + r_s2_tr[r];
            end
        end
    end

    // Stage 4: full row sums at exact precision
    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_s4_mn[r] <= r_s3_mn_a[r] + r_s3_mn_b[r];
                r_s4_mx[r] <= r_s3_mx_a[r] + r_s3_mx_b[r];
            end
        end
    end

    // Stage 5: shift down and saturate into the output register
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_out_mn[r] <= sat_shift(r_s4_mn[r], FRAC_BITS);
                r_out_mx[r] <= sat_shift(r_s4_mx[r], FRAC_BITS);
            end
        end
    end

    assign o_m_axis_tvalid = r_v[NUM_STAGES];
    assign o_m_axis_tdata  = {r_out_mx[2], r_out_mx[1], r_out_mx[0],
                              r_out_mn[2], r_out_mn[1], r_out_mn[0]};

endmodule

`default_nettype wire

// File: hw/rtl/tbb_checker.sv
// -----------------------------------------------------------------------------
// tbb_checker: port-level checks for the box transform
// Watches the stream ports for output hold behavior, ordered bounds and the
// number of transactions in flight.
// -----------------------------------------------------------------------------
`default_nettype none

`include "transform_bounding_box_defines.svh"

module tbb_checker
    import tbb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_axis_tvalid,
    input wire logic             o_s_axis_tready,
    input wire logic             o_m_axis_tvalid,
    input wire logic             i_m_axis_tready,
    input wire logic [BOX_W-1:0] o_m_axis_tdata
);

    localparam int unsigned MAX_INFLIGHT = 5;

    logic       w_in_acc;
    logic       w_out_acc;
    logic [2:0] r_inflight;
    logic [2:0] n_inflight;
    t_coord     w_mn [NUM_ROWS];
    t_coord     w_mx [NUM_ROWS];
    logic       w_ordered;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Track transactions accepted but not yet delivered
    always_comb begin
        n_inflight = r_inflight + 3'(w_in_acc) - 3'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // Each output minimum must not exceed its maximum
    always_comb begin
        w_ordered = 1'b1;
        for (int k = 0; k < NUM_ROWS; k++) begin
            w_mn[k] = o_m_axis_tdata[k*COORD_W +: COORD_W];
            w_mx[k] = o_m_axis_tdata[(k+NUM_ROWS)*COORD_W +: COORD_W];
            if (w_mn[k] > w_mx[k]) begin
                w_ordered = 1'b0;
            end
        end
    end

    `TBB_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "output valid dropped while stalled")
    `TBB_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "output data changed while stalled")
    `TBB_ASSERT_NOW(a_bounds_ordered, i_clk, i_rst_n, o_m_axis_tvalid, w_ordered, "output minimum above maximum")
    `TBB_ASSERT_NOW(a_inflight_range, i_clk, i_rst_n, o_m_axis_tvalid, r_inflight != 3'd0 && r_inflight <= 3'(MAX_INFLIGHT), "output without pending transaction or too many in flight")

endmodule

bind transform_bounding_box tbb_checker u_tbb_checker (.*);

`default_nettype wire

// File: tb/transform_bounding_box_scoreboard.sv
// -----------------------------------------------------------------------------
// transform_bounding_box_scoreboard: bounds prediction and result compare
// Watches the configuration, box and result channels. It keeps its own copy of
// the 3x4 matrix, predicts the bounds of the eight transformed corners of every
// accepted box, and checks each result field against the oldest prediction.
// -----------------------------------------------------------------------------
module transform_bounding_box_scoreboard
    import tbb_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    input  wire logic                 i_s_axis_tready,
    input  wire logic [BOX_W-1:0]     i_s_axis_tdata,
    input  wire logic                 i_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    input  wire logic [BOX_W-1:0]     i_m_axis_tdata,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire t_cfg_idx             i_cfg_index,
    input  wire t_cfg_data            i_cfg_data,
    output int unsigned               o_mismatches,
    output int unsigned               o_pending,
    output int unsigned               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Wide enough for three full products plus the shifted translation
    typedef logic signed [SUM_W+FRAC_BITS-1:0] t_row_acc;

    localparam t_coord   ONE     = t_coord'(1 << FRAC_BITS);
    localparam t_row_acc ACC_MAX = COORD_MAX;
    localparam t_row_acc ACC_MIN = COORD_MIN;

    localparam string FIELD_NAME [6] = '{"min_x", "min_y", "min_z",
                                         "max_x", "max_y", "max_z"};

    t_coord             mtx [3][4];
    logic [BOX_W-1:0]   expected_bounds [$];

    // One matrix row applied to a point with w = 1: exact sum, floor shift, clamp
    function automatic t_coord transform_row(input int r, input t_coord x,
                                             input t_coord y, input t_coord z);
        t_row_acc wx, wy, wz, m0, m1, m2, m3, acc;
        wx  = x;
        wy  = y;
        wz  = z;
        m0  = mtx[r][0];
        m1  = mtx[r][1];
        m2  = mtx[r][2];
        m3  = mtx[r][3];
        acc = m0 * wx + m1 * wy + m2 * wz + (m3 <<< FRAC_BITS);
        acc = acc >>> FRAC_BITS;
        if (acc > ACC_MAX) begin
            return COORD_MAX;
        end else if (acc < ACC_MIN) begin
            return COORD_MIN;
        end
        return acc[COORD_W-1:0];
    endfunction

    // Transform all eight corners and keep the per-axis extremes
    function automatic logic [BOX_W-1:0] predict_bounds(input logic [BOX_W-1:0] box);
        t_coord           lo [3], hi [3], pt [3], mn [3], mx [3], v;
        logic [BOX_W-1:0] bounds;
        for (int k = 0; k < 3; k++) begin
            lo[k] = box[k*COORD_W +: COORD_W];
            hi[k] = box[(k+3)*COORD_W +: COORD_W];
        end
        for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < 3; k++) begin
                pt[k] = c[k] ? hi[k] : lo[k];
            end
            for (int r = 0; r < 3; r++) begin
                v = transform_row(r, pt[0], pt[1], pt[2]);
                if (c == 0 || v < mn[r]) mn[r] = v;
                if (c == 0 || v > mx[r]) mx[r] = v;
            end
        end
        for (int k = 0; k < 3; k++) begin
            bounds[k*COORD_W +: COORD_W]     = mn[k];
            bounds[(k+3)*COORD_W +: COORD_W] = mx[k];
        end
        return bounds;
    endfunction

    // Track the matrix, queue predictions, compare results
    always @(posedge i_clk) begin : watch
        logic [BOX_W-1:0] want;
        t_coord           want_f, got_f;
        int unsigned      errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    mtx[r][c] = (r == c) ? ONE : '0;
                end
            end
            expected_bounds.delete();
            o_mismatches <= 0;
            o_checked    <= 0;
        end else begin
            // register write transaction; spare indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROW0_C01: begin
                        mtx[0][0] = i_cfg_data[31:0];
                        mtx[0][1] = i_cfg_data[63:32];
                    end
                    REG_ROW0_C23: begin
                        mtx[0][2] = i_cfg_data[31:0];
                        mtx[0][3] = i_cfg_data[63:32];
                    end
                    REG_ROW1_C01: begin
                        mtx[1][0] = i_cfg_data[31:0];
                        mtx[1][1] = i_cfg_data[63:32];
                    end
                    REG_ROW1_C23: begin
                        mtx[1][2] = i_cfg_data[31:0];
                        mtx[1][3] = i_cfg_data[63:32];
                    end
                    REG_ROW2_C01: begin
                        mtx[2][0] = i_cfg_data[31:0];
                        mtx[2][1] = i_cfg_data[63:32];
                    end
                    REG_ROW2_C23: begin
                        mtx[2][2] = i_cfg_data[31:0];
                        mtx[2][3] = i_cfg_data[63:32];
                    end
                    default: ;
                endcase
            end
            // box transaction: predict its bounds
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_bounds.push_back(predict_bounds(i_s_axis_tdata));
            end
            // result transaction: compare against the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_bounds.size() == 0) begin
                    $error("result %h arrived with no box outstanding", i_m_axis_tdata);
                    errs++;
                end else begin
                    want = expected_bounds.pop_front();
                    o_checked <= o_checked + 1;
                    for (int k = 0; k < 6; k++) begin
                        want_f = want[k*COORD_W +: COORD_W];
                        got_f  = i_m_axis_tdata[k*COORD_W +: COORD_W];
                        if (want_f !== got_f) begin
                            $error("%s: expected %0d, got %0d", FIELD_NAME[k], want_f, got_f);
                            errs++;
                        end
                    end
                end
            end
            // fold this edge's mismatches into the running count
            o_mismatches <= o_mismatches + errs;
        end
        o_pending <= expected_bounds.size();
    end

endmodule

// File: tb/transform_bounding_box_tb.sv
// -----------------------------------------------------------------------------
// transform_bounding_box_tb: box transform stimulus and verdict
// Drives boxes and matrix writes into the block under several matrix settings,
// from identity to all-extreme entries, with random gaps on both stream sides,
// one long output hold-off, and a scoreboard that checks every result.
// -----------------------------------------------------------------------------
module transform_bounding_box_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbb_pkg::*;

    typedef enum {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_e;
    typedef enum {
        MAT_IDENTITY, MAT_ALL_MAX, MAT_ALL_MIN, MAT_EXTREME,
        MAT_FULL, MAT_EDGE, MAT_NARROW, MAT_MIXED
    } mat_mode_e;

    localparam int unsigned FRAC           = FRAC_BITS_DEF;
    localparam t_coord      ONE            = t_coord'(1 << FRAC);
    localparam int          PIPE_LATENCY   = 5;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          RANDOM_PHASES  = 10;
    localparam int          PHASE_BOXES    = 145;
    localparam int          PRESSURE_PHASE = 3;

    // Indexes past the matrix: writes there must leave it untouched
    localparam t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    localparam t_cfg_idx MATRIX_REGS [6] = '{REG_ROW0_C01, REG_ROW0_C23,
                                             REG_ROW1_C01, REG_ROW1_C23,
                                             REG_ROW2_C01, REG_ROW2_C23};

    localparam mat_mode_e PHASE_MATRIX [RANDOM_PHASES] = '{
        MAT_NARROW, MAT_FULL, MAT_EDGE, MAT_IDENTITY, MAT_ALL_MAX,
        MAT_ALL_MIN, MAT_MIXED, MAT_NARROW, MAT_MIXED, MAT_MIXED};

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [BOX_W-1:0] s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [BOX_W-1:0] m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    t_cfg_idx         cfg_index = '0;
    t_cfg_data        cfg_data  = '0;

    int unsigned mismatches, pending, checked;
    int unsigned boxes_sent   = 0;
    int unsigned reg_writes   = 0;
    int unsigned stalled_cyc  = 0;
    idle_mode_e  tx_mode      = IDLE_SOME;
    idle_mode_e  rx_mode      = IDLE_SOME;
    bit          hold_req     = 1'b0;

    initial forever #1 clk = ~clk;

    transform_bounding_box #(.FRAC_BITS(FRAC)) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    transform_bounding_box_scoreboard #(.FRAC_BITS(FRAC)) bounds_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    function automatic int draw_wait(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 16)) : 0;
            default:   return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic t_coord narrow_value(input int unsigned half_span);
        return t_coord'($urandom_range(0, 2 * half_span) - half_span);
    endfunction

    function automatic t_coord edge_value();
        case ($urandom_range(0, 6))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            5:       return ONE;
            default: return -ONE;
        endcase
    endfunction

    // Mostly full-range or modest coordinates, the rest special values such as the range corners
    function automatic t_coord rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) return t_coord'($urandom);
        if (pick < 17) return narrow_value(32'h0010_0000);
        return edge_value();
    endfunction

    // Ordered axes most of the time; now and then an axis with min above max
    function automatic logic [BOX_W-1:0] rand_box();
        logic [BOX_W-1:0] box;
        t_coord           a, b, t;
        bit               flip;
        for (int k = 0; k < 3; k++) begin
            a    = rand_coord();
            b    = rand_coord();
            flip = ($urandom_range(0, 11) == 0);
            if (flip ? (a < b) : (a > b)) begin
                t = a;
                a = b;
                b = t;
            end
            box[k*COORD_W +: COORD_W]     = a;
            box[(k+3)*COORD_W +: COORD_W] = b;
        end
        return box;
    endfunction

    function automatic logic [BOX_W-1:0] pack_box(input t_coord mnx, input t_coord mny,
                                                  input t_coord mnz, input t_coord mxx,
                                                  input t_coord mxy, input t_coord mxz);
        return {mxz, mxy, mxx, mnz, mny, mnx};
    endfunction

    function automatic t_coord matrix_entry(input mat_mode_e mode, input int row,
                                            input int col);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (mode)
            MAT_IDENTITY: return (row == col) ? ONE : '0;
            MAT_ALL_MAX:  return COORD_MAX;
            MAT_ALL_MIN:  return COORD_MIN;
            MAT_EXTREME:  begin
                if (row == 0) return COORD_MAX;
                if (row == 1) return COORD_MIN;
                return (col % 2 == 1) ? COORD_MAX : COORD_MIN;
            end
            MAT_FULL:     return t_coord'($urandom);
            MAT_EDGE:     return edge_value();
            MAT_NARROW:   return narrow_value(32'h0004_0000);
            default: begin
                if (pick < 6) return narrow_value(32'h0004_0000);
                if (pick < 8) return edge_value();
                return t_coord'($urandom);
            end
        endcase
    endfunction

    // Raise valid and hold it until the register write transaction happens
    task automatic cfg_write(input t_cfg_idx idx, input t_cfg_data value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
    endtask

    task automatic load_matrix(input mat_mode_e mode, input bit every_reg, input bit spare);
        t_coord lo_e, hi_e;
        for (int r = 0; r < 3; r++) begin
            for (int h = 0; h < 2; h++) begin
                if (every_reg || $urandom_range(0, 1) == 1) begin
                    lo_e = matrix_entry(mode, r, 2 * h);
                    hi_e = matrix_entry(mode, r, 2 * h + 1);
                    cfg_write(MATRIX_REGS[2 * r + h], {hi_e, lo_e});
                end
            end
        end
        if (spare) begin
            cfg_write(CFG_SPARE_LO, {$urandom, $urandom});
            cfg_write(CFG_SPARE_HI, {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
    endtask

    // Optional gap, then offer the box until the input transaction happens
    task automatic send_box(input logic [BOX_W-1:0] box);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= box;
        do @(posedge clk); while (!s_ready);
        boxes_sent++;
    endtask

    // Stop offering, wait out every outstanding result, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Result side: random stalls per result, one long hold-off on request
    initial begin : result_sink
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = draw_wait(rx_mode);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
        end
    end

    // Abort when no transaction of any kind happens for too long
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stalled_cyc <= 0;
        end else if (stalled_cyc == WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("transform_bounding_box_tb: done, errors");
            $finish;
        end else begin
            stalled_cyc <= stalled_cyc + 1;
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset: range corners, inverted and tiny boxes
        send_box(pack_box(0, 0, 0, 0, 0, 0));
        send_box(pack_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(pack_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(pack_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(pack_box(ONE, 2 * ONE, 3 * ONE, -ONE, -2 * ONE, -3 * ONE));
        send_box(pack_box(-1, -1, -1, 1, 1, 1));
        send_box(pack_box(COORD_MIN, 0, -1, COORD_MAX, 1, 0));
        drain();

        // extreme matrix: saturation in both directions, spare indexes ignored
        load_matrix(MAT_EXTREME, 1'b1, 1'b1);
        send_box(pack_box(0, 0, 0, 0, 0, 0));
        send_box(pack_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(pack_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(pack_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(pack_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(pack_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_box(rand_box());
        drain();

        // random phases, one matrix setting each
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_matrix(PHASE_MATRIX[p], p < 6, p == 0 || p >= 6);
            if (p == PRESSURE_PHASE) begin
                tx_mode  = IDLE_NONE;
                rx_mode  = IDLE_NONE;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_BOXES; n++) begin
                if (p != PRESSURE_PHASE && n % 32 == 0) begin
                    tx_mode = idle_mode_e'($urandom_range(0, 2));
                    rx_mode = idle_mode_e'($urandom_range(0, 2));
                end
                send_box(rand_box());
            end
            drain();
        end

        if (pending != 0) begin
            $error("%0d predicted results never arrived", pending);
        end
        $display("covered %0d boxes under %0d matrix settings, %0d register writes",
                 boxes_sent, RANDOM_PHASES + 2, reg_writes);
        $display("compared %0d results, %0d field mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("transform_bounding_box_tb: done, clean");
        end else begin
            $display("transform_bounding_box_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: transform_bounding_box.f
+incdir+hw/rtl
hw/rtl/tbb_pkg.sv
hw/rtl/transform_bounding_box.sv
hw/rtl/tbb_checker.sv
tb/transform_bounding_box_scoreboard.sv
tb/transform_bounding_box_tb.sv
